### rtl/mersenne_twister_ranged_rng_defines.svh
// Assertion macros for the ranged twister generator.
`ifndef MERSENNE_TWISTER_RANGED_RNG_DEFINES_SVH
`define MERSENNE_TWISTER_RANGED_RNG_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge out of reset
`define MTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtr: property violated");
// Condition that must never be seen out of reset
`define MTR_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mtr: forbidden condition seen");
`else
`define MTR_ASSERT(lbl, prop)
`define MTR_NEVER(lbl, expr)
`endif
`endif

### rtl/mtr_pkg.sv
package mtr_pkg;

  localparam int TW_N  = 624;
  localparam int TW_M  = 397;
  localparam int IDX_W = 10;

  localparam logic [31:0] TW_MATRIX   = 32'h9908B0DF;
  localparam logic [31:0] TEMPER_B    = 32'h9D2C5680;
  localparam logic [31:0] TEMPER_C    = 32'hEFC60000;
  localparam logic [31:0] INIT_MUL    = 32'd1812433253;
  localparam logic [31:0] RANGE_FAULT = 32'h80000000;
  localparam logic [31:0] SEED_RST    = 32'd5489;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TW_N - 1);
  localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(TW_N);

  // Request commands
  localparam logic [1:0] CMD_RAW   = 2'd0;
  localparam logic [1:0] CMD_SCALE = 2'd1;
  localparam logic [1:0] CMD_EXACT = 2'd2;
  localparam logic [1:0] CMD_SEED  = 2'd3;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_SEED0, OP_IMUL, OP_IWR, OP_RGST, OP_RGLD,
    OP_RGRD, OP_RGWR, OP_IDXF, OP_DRD, OP_TMP, OP_MUL, OP_LSTART, OP_LIM,
    OP_DSTART, OP_PUSH
  } op_t;

  // Result source
  typedef enum logic [2:0] {
    SEL_WORD, SEL_FAULT, SEL_LO, SEL_SCALE, SEL_SUM, SEL_REM
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic       idx_end;
    logic       cnt_last;
    logic [1:0] cmd;
    logic       rev;
    logic       eq;
    logic       full;
    logic       div_done;
    logic       accept;
    logic       out_busy;
  } dp_stat_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

### rtl/mersenne_twister_ranged_rng.sv
// MT19937 generator with ranged outputs. One request at a time: in_tready is high only while
// the block is idle. A raw word is decoded, read from the store and tempered; whenever the
// 624-word store is used up, the next draw first regenerates it through the single-write,
// dual-read store. Scaled range adds a step on the 32x32 multiplier. Exact range runs the
// serial divider once for the limit and once per drawn word, again whenever a word is
// rejected; a full 32-bit span skips the divider. A reseed returns no result. After reset
// the store is cleared in one pass before the first request is taken; configuration
// writes are taken as ever.
`include "mersenne_twister_ranged_rng_defines.svh"
module mersenne_twister_ranged_rng
  import mtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] range_min, [63:32] range_max
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [0:0]  out_tuser,  // [0] range_error
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] seed_r;

  // Seed register
  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= SEED_RST;
    else if (cfg_wr_en) seed_r <= cfg_wr_data;
  end

  mtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mtr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (in_tuser),
    .in_min     (in_tdata[31:0]),
    .in_max     (in_tdata[63:32]),
    .seed       (seed_r),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (out_tdata),
    .out_err    (out_tuser[0])
  );

  `MTR_ASSERT(a_busy_after_transfer, in_tvalid && in_tready |=> !in_tready)
  `MTR_ASSERT(a_result_from_busy, $rose(out_tvalid) |-> $past(!in_tready))
  `MTR_NEVER(a_error_value, out_tvalid && out_tuser[0] && out_tdata != RANGE_FAULT)

endmodule

### rtl/mtr_ctrl.sv
module mtr_ctrl
  import mtr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_CLR     = 18'b1 << 0,
    S_IDLE    = 18'b1 << 1,
    S_DEC     = 18'b1 << 2,
    S_SEED    = 18'b1 << 3,
    S_IMUL    = 18'b1 << 4,
    S_IWR     = 18'b1 << 5,
    S_RGST    = 18'b1 << 6,
    S_RGLD    = 18'b1 << 7,
    S_RGRD    = 18'b1 << 8,
    S_RGWR    = 18'b1 << 9,
    S_IDXF    = 18'b1 << 10,
    S_DRD     = 18'b1 << 11,
    S_TMP     = 18'b1 << 12,
    S_MUL     = 18'b1 << 13,
    S_DST     = 18'b1 << 14,
    S_DDIV    = 18'b1 << 15,
    S_LDIV    = 18'b1 << 16,
    S_FIN_SEL = 18'b1 << 17
  } state_t;

  state_t state_r, state_nxt;
  logic   seeding_r, seeding_nxt;
  state_t draw_entry;
  sel_t   sel_c;

  // Regenerate first when the store is used up
  assign draw_entry = stat.idx_end ? S_RGST : S_DRD;

  // Pick the result source
  always_comb begin
    if (stat.cmd == CMD_RAW)        sel_c = SEL_WORD;
    else if (stat.rev)              sel_c = SEL_FAULT;
    else if (stat.eq)               sel_c = SEL_LO;
    else if (stat.cmd == CMD_SCALE) sel_c = SEL_SCALE;
    else if (stat.full)             sel_c = SEL_SUM;
    else                            sel_c = SEL_REM;
  end

  // Sequence the datapath
  always_comb begin
    state_nxt   = state_r;
    seeding_nxt = seeding_r;
    cmd.sel     = sel_c;
    cmd.op      = OP_NONE;
    in_tready   = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.cmd)
          CMD_SEED: state_nxt = S_SEED;
          CMD_RAW:  state_nxt = draw_entry;
          default: begin
            if (stat.rev || stat.eq) begin
              state_nxt = S_FIN_SEL;
            end else if (stat.cmd == CMD_SCALE || stat.full) begin
              state_nxt = draw_entry;
            end else begin
              cmd.op    = OP_LSTART;
              state_nxt = S_LDIV;
            end
          end
        endcase
      end
      S_SEED: begin
        cmd.op      = OP_SEED0;
        seeding_nxt = 1'b1;
        state_nxt   = S_IMUL;
      end
      S_IMUL: begin
        cmd.op    = OP_IMUL;
        state_nxt = S_IWR;
      end
      S_IWR: begin
        cmd.op    = OP_IWR;
        state_nxt = stat.cnt_last ? S_RGST : S_IMUL;
      end
      S_RGST: begin
        cmd.op    = OP_RGST;
        state_nxt = S_RGLD;
      end
      S_RGLD: begin
        cmd.op    = OP_RGLD;
        state_nxt = S_RGWR;
      end
      S_RGRD: begin
        cmd.op    = OP_RGRD;
        state_nxt = S_RGWR;
      end
      S_RGWR: begin
        cmd.op = OP_RGWR;
        if (stat.cnt_last) state_nxt = seeding_r ? S_IDXF : S_DRD;
        else               state_nxt = S_RGRD;
      end
      S_IDXF: begin
        cmd.op      = OP_IDXF;
        seeding_nxt = 1'b0;
        state_nxt   = S_IDLE;
      end
      S_DRD: begin
        cmd.op    = OP_DRD;
        state_nxt = S_TMP;
      end
      S_TMP: begin
        cmd.op = OP_TMP;
        if (stat.cmd == CMD_SCALE)                     state_nxt = S_MUL;
        else if (stat.cmd == CMD_EXACT && !stat.full)  state_nxt = S_DST;
        else                                           state_nxt = S_FIN_SEL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_FIN_SEL;
      end
      S_DST: begin
        cmd.op    = OP_DSTART;
        state_nxt = S_DDIV;
      end
      S_DDIV: begin
        if (stat.div_done) state_nxt = stat.accept ? S_FIN_SEL : draw_entry;
      end
      S_LDIV: begin
        if (stat.div_done) begin
          cmd.op    = OP_LIM;
          state_nxt = draw_entry;
        end
      end
      S_FIN_SEL: begin
        // Result ready: wait for a free output register
        if (!stat.out_busy) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      seeding_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seeding_r <= seeding_nxt;
    end
  end

endmodule

### rtl/mtr_div.sv
module mtr_div
  import mtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r, r_r, d_r;
  logic [32:0] shifted, diff;

  // One restoring step per cycle
  assign shifted = {r_r, q_r[31]};
  assign diff    = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, d_r}) begin
        r_r <= diff[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= shifted[31:0];
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

### rtl/mtr_dp.sv
module mtr_dp
  import mtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_min,
  input  logic [31:0] in_max,
  input  logic [31:0] seed,
  input  logic        out_tready,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_err
);

  logic [31:0]      mem [0:TW_N-1];
  logic [31:0]      rda_r, rdb_r;
  logic [IDX_W-1:0] addr_a, wa;
  logic             we;
  logic [31:0]      wd;

  logic [IDX_W-1:0] idx_r, cnt_r, nxt, far;
  logic [IDX_W:0]   far_sum;
  logic [31:0]      p_r, wk_r, word_r, lim_r, lo_r, hi_r;
  logic [1:0]       cmd_r;
  logic [63:0]      prod_r, mul_p;
  logic [31:0]      mul_a, mul_b, pmix, iwr_val, twist, y;
  logic [31:0]      span, iv, off, clip, res;
  logic             out_valid_r, out_err_r;
  logic [31:0]      out_value_r;
  logic             dv_start, dv_done;
  logic [31:0]      dv_dividend, dv_q, dv_r;

  // Twist neighbors of the word being regenerated
  assign nxt     = (cnt_r == IDX_LAST) ? '0 : cnt_r + 1'b1;
  assign far_sum = {1'b0, cnt_r} + (IDX_W + 1)'(TW_M);
  assign far     = (far_sum >= (IDX_W + 1)'(TW_N)) ?
                   IDX_W'(far_sum - (IDX_W + 1)'(TW_N)) : far_sum[IDX_W-1:0];
  assign y       = {wk_r[31], rda_r[30:0]};
  assign twist   = rdb_r ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);

  // Shared multiplier: seeding recurrence or range scaling
  assign pmix    = p_r ^ (p_r >> 30);
  assign mul_a   = (cmd.op == OP_MUL) ? iv : INIT_MUL;
  assign mul_b   = (cmd.op == OP_MUL) ? word_r : pmix;
  assign mul_p   = {32'd0, mul_a} * {32'd0, mul_b};
  assign iwr_val = prod_r[31:0] + {{(32 - IDX_W){1'b0}}, cnt_r};

  // Range arithmetic
  assign span = hi_r - lo_r;
  assign iv   = span + 32'd1;
  assign off  = (span == 32'hFFFFFFFF) ? word_r : prod_r[63:32];
  assign clip = (off > span) ? span : off;

  always_comb begin
    case (cmd.sel)
      SEL_WORD:  res = word_r;
      SEL_FAULT: res = RANGE_FAULT;
      SEL_LO:    res = lo_r;
      SEL_SCALE: res = lo_r + clip;
      SEL_SUM:   res = lo_r + word_r;
      SEL_REM:   res = lo_r + dv_r;
      default:   res = word_r;
    endcase
  end

  // Store port selection
  always_comb begin
    we     = 1'b0;
    wa     = cnt_r;
    wd     = '0;
    addr_a = idx_r;
    case (cmd.op)
      OP_CLR:   we = 1'b1;
      OP_SEED0: begin
        we = 1'b1;
        wa = '0;
        wd = seed;
      end
      OP_IWR: begin
        we = 1'b1;
        wd = iwr_val;
      end
      OP_RGST:  addr_a = '0;
      OP_RGLD:  addr_a = nxt;
      OP_RGRD:  addr_a = nxt;
      OP_RGWR: begin
        we = 1'b1;
        wd = twist;
      end
      default: ;
    endcase
  end

  // Twister store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rda_r <= mem[addr_a];
    rdb_r <= mem[far];
  end

  // Divider: limit for exact mode, then quotient per drawn word
  assign dv_start    = (cmd.op == OP_LSTART) || (cmd.op == OP_DSTART);
  assign dv_dividend = (cmd.op == OP_LSTART) ? 32'hFFFFFFFF : word_r;

  mtr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (iv),
    .done     (dv_done),
    .quo      (dv_q),
    .rem      (dv_r)
  );

  // Counters and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_PUSH) || (out_valid_r && !out_tready);
      case (cmd.op)
        OP_CLR:   cnt_r <= cnt_r + 1'b1;
        OP_SEED0: cnt_r <= IDX_W'(1);
        OP_IWR:   cnt_r <= cnt_r + 1'b1;
        OP_RGST:  cnt_r <= '0;
        OP_RGWR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IDX_LAST) idx_r <= '0;
        end
        OP_IDXF:  idx_r <= IDX_END;
        OP_DRD:   idx_r <= idx_r + 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r <= in_command;
        lo_r  <= in_min;
        hi_r  <= in_max;
      end
      OP_SEED0: p_r    <= seed;
      OP_IMUL:  prod_r <= mul_p;
      OP_IWR:   p_r    <= iwr_val;
      OP_RGLD:  wk_r   <= rda_r;
      OP_RGWR:  wk_r   <= rda_r;
      OP_TMP:   word_r <= temper(rda_r);
      OP_MUL:   prod_r <= mul_p;
      OP_LIM:   lim_r  <= dv_q + ((dv_r == span) ? 32'd1 : 32'd0);
      OP_PUSH: begin
        out_value_r <= res;
        out_err_r   <= (cmd.sel == SEL_FAULT);
      end
      default: ;
    endcase
  end

  // Status back to the controller
  always_comb begin
    stat.idx_end  = (idx_r >= IDX_END);
    stat.cnt_last = (cnt_r == IDX_LAST);
    stat.cmd      = cmd_r;
    stat.rev      = ($signed(hi_r) < $signed(lo_r));
    stat.eq       = (hi_r == lo_r);
    stat.full     = (span == 32'hFFFFFFFF);
    stat.div_done = dv_done;
    stat.accept   = (dv_q < lim_r);
    stat.out_busy = out_valid_r && !out_tready;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_err   = out_err_r;

endmodule

### dv/mersenne_twister_ranged_rng_checker.sv
`timescale 1ns / 100ps
module mersenne_twister_ranged_rng_checker
  import mtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] range_min, [63:32] range_max
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] value
  input  logic [0:0]  out_tuser,  // [0] range_error
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [31:0] value;
    logic        range_error;
  } rng_result_t;

  logic [31:0]  twister_store [0:TW_N-1];
  int unsigned  read_pos;
  logic [31:0]  seed_reg;
  rng_result_t  expected_results [$];

  // Refill the whole store from its previous contents
  function automatic void refill_store();
    logic [31:0] y;
    int unsigned nxt;
    int unsigned far_pos;
    for (int k = 0; k < TW_N; k++) begin
      nxt = (k + 1 == TW_N) ? 0 : k + 1;
      far_pos = k + TW_M;
      if (far_pos >= TW_N) far_pos -= TW_N;
      y = (twister_store[k] & 32'h80000000) | (twister_store[nxt] & 32'h7FFFFFFF);
      twister_store[k] = twister_store[far_pos] ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'h0);
    end
    read_pos = 0;
  endfunction

  // Take the next word and temper it
  function automatic logic [31:0] next_word();
    logic [31:0] y;
    if (read_pos >= TW_N) refill_store();
    y = twister_store[read_pos];
    read_pos = (read_pos + 1) & 10'h3FF;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Seed the store, then discard one full store of words
  function automatic void seed_store(logic [31:0] seed);
    logic [31:0] p;
    logic [31:0] junk;
    twister_store[0] = seed;
    for (int i = 1; i < TW_N; i++) begin
      p = twister_store[i-1];
      twister_store[i] = INIT_MUL * (p ^ (p >> 30)) + i;
    end
    read_pos = TW_N;
    for (int i = 0; i < TW_N; i++) junk = next_word();
  endfunction

  // Work out the result of one request; returns 0 when none is produced
  function automatic bit predict_request(logic [1:0] cmd, logic [31:0] lo, logic [31:0] hi,
                                         output rng_result_t res);
    logic [32:0] interval;
    logic [65:0] prod;
    logic [31:0] off, w, iv, limit;
    res.value = 32'h0;
    res.range_error = 1'b0;
    if (cmd == CMD_SEED) begin
      seed_store(seed_reg);
      return 0;
    end
    if (cmd == CMD_RAW) begin
      res.value = next_word();
    end else if ($signed(hi) < $signed(lo)) begin
      res.value = RANGE_FAULT;
      res.range_error = 1'b1;
    end else if (hi == lo) begin
      res.value = lo;
    end else begin
      interval = {1'b0, hi - lo} + 33'd1;
      if (cmd == CMD_SCALE) begin
        w = next_word();
        prod = {33'b0, interval} * {34'b0, w};
        off = prod[63:32];
        if (off > hi - lo) off = hi - lo;
        res.value = lo + off;
      end else if (interval[32]) begin
        res.value = lo + next_word();
      end else begin
        iv = interval[31:0];
        limit = 32'hFFFFFFFF / iv;
        if (32'hFFFFFFFF % iv == iv - 1) limit++;
        do begin
          w = next_word();
        end while (w / iv >= limit);
        res.value = lo + (w % iv);
      end
    end
    return 1;
  endfunction

  task automatic report(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending = 0;

  // Track config writes, accepted requests and returned results
  always @(posedge clk) begin
    rng_result_t r;
    rng_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < TW_N; i++) twister_store[i] = 32'h0;
      read_pos = 0;
      seed_reg = SEED_RST;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) seed_reg = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (predict_request(in_tuser, in_tdata[31:0], in_tdata[63:32], r))
          expected_results.push_back(r);
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result value=%h err=%b", out_tdata, out_tuser[0]));
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata !== exp_r.value)
            report($sformatf("value %h, expected %h", out_tdata, exp_r.value));
          if (out_tuser[0] !== exp_r.range_error)
            report($sformatf("range_error %b, expected %b", out_tuser[0], exp_r.range_error));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### dv/mersenne_twister_ranged_rng_test.sv
`timescale 1ns / 100ps
module mersenne_twister_ranged_rng_test;
  import mtr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] range_min, [63:32] range_max
  logic [1:0]  in_tuser;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] value
  logic [0:0]  out_tuser;  // [0] range_error
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  int          fail_count;
  int          pending;
  int          burst_left;
  int          stall_mode;
  int          stall_cnt;

  mersenne_twister_ranged_rng u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  mersenne_twister_ranged_rng_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver stall: switch between always ready, random and periodic patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      stall_mode <= 0;
      stall_cnt  <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_tready <= (stall_cnt % 7) < 3;
        end
      endcase
    end
  end

  // Transfer one request; hold valid across a burst, drop it for gaps
  task automatic send_req(logic [1:0] cmd, logic [31:0] mn, logic [31:0] mx);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {mx, mn};
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end
  endtask

  // Drain all results, let a pending reseed finish, then write the seed
  task automatic write_seed(logic [31:0] seed);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    while (!in_tready) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= seed;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random request with a range drawn from several shapes
  task automatic send_random();
    logic [1:0]  cmd;
    logic [31:0] mn, mx;
    int k;
    k = $urandom_range(0, 99);
    cmd = (k < 30) ? CMD_RAW : (k < 62) ? CMD_SCALE : (k < 98) ? CMD_EXACT : CMD_SEED;
    mn = $urandom();
    case ($urandom_range(0, 6))
      0: mx = $urandom();
      1: mx = mn + $urandom_range(1, 10);
      2: mx = mn + $urandom_range(1, 1000000);
      3: mx = mn;
      4: mx = mn - $urandom_range(1, 100);
      5: begin
        mn = 32'h80000000 + $urandom_range(0, 3);
        mx = 32'h7FFFFFFF - $urandom_range(0, 3);
      end
      default: begin
        mn = 32'hC0000000 - $urandom_range(0, 7);
        mx = 32'h40000000;
      end
    endcase
    send_req(cmd, mn, mx);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 64'h0;
    in_tuser    = CMD_RAW;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 32'h0;
    burst_left  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (!in_tready) @(posedge clk);

    // Cleared store gives zero words until seeded
    send_req(CMD_RAW, 32'hFFFFFFFF, 32'h0);
    send_req(CMD_EXACT, 32'h0, 32'h6);
    // Reseed with the reset value of the seed
    send_req(CMD_SEED, 32'h0, 32'h0);
    send_req(CMD_RAW, 32'h0, 32'h0);
    send_req(CMD_SCALE, 32'h80000000, 32'h7FFFFFFF);
    send_req(CMD_EXACT, 32'h80000000, 32'h7FFFFFFF);
    send_req(CMD_SCALE, 32'h7FFFFFFF, 32'h80000000);
    send_req(CMD_EXACT, 32'h00000005, 32'hFFFFFFFF);
    send_req(CMD_SCALE, 32'h12345678, 32'h12345678);
    send_req(CMD_EXACT, 32'h80000000, 32'h80000000);
    send_req(CMD_SCALE, 32'h0, 32'h1);
    send_req(CMD_EXACT, 32'h0, 32'h1);
    send_req(CMD_EXACT, 32'hC0000000, 32'h40000000);
    send_req(CMD_EXACT, 32'hFFFFFFFD, 32'h7);
    send_req(CMD_SCALE, 32'h7FFFFFFE, 32'h7FFFFFFF);
    send_req(CMD_EXACT, 32'h80000000, 32'h7FFFFFFE);

    // Extreme and random seeds, each followed by a random stretch
    write_seed(32'h0);
    send_req(CMD_SEED, 32'h0, 32'h0);
    repeat (500) send_random();
    write_seed(32'hFFFFFFFF);
    send_req(CMD_SEED, 32'h0, 32'h0);
    repeat (500) send_random();
    write_seed($urandom());
    send_req(CMD_SEED, 32'h0, 32'h0);
    repeat (500) send_random();
    write_seed(SEED_RST);
    send_req(CMD_SEED, 32'h0, 32'h0);
    repeat (500) send_random();

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
